// ===== rtl/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared types and constants for the depth pixel to point back-projection.
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int Z_W       = 16;
  localparam int XY_W      = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  // Counter compares are done at a width that holds any legal row length.
  localparam int CNT_CMP_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd7;

  localparam logic        FMT_MM    = 1'b0;
  localparam logic        FMT_FLOAT = 1'b1;

  typedef struct packed {
    logic        depth_format;
    logic [15:0] min_depth_mm;
    logic [15:0] max_depth_mm;
    logic [15:0] focal_x;
    logic [15:0] focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [12:0] image_width;
  } cfg_t;

endpackage

// ===== rtl/dpp_fifo.sv =====
// ----------------------------------------------------------------------------
// dpp_fifo
// Short queue between the classifying front end and the projection back end.
// ----------------------------------------------------------------------------
module dpp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dpp_front.sv =====
// ----------------------------------------------------------------------------
// dpp_front
// Pixel intake: raster position counters, depth decode and range check.
// ----------------------------------------------------------------------------
module dpp_front
  import dpp_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          accept,
  input  logic [31:0]   depth_word,
  input  logic          frame_start,
  output logic          ok,
  output logic [Z_W-1:0] z,
  output logic [CW-1:0] u,
  output logic [RW-1:0] v
);

  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CNT_CMP_W-1:0] limit, col_inc, row_inc;

  logic        f_sign;
  logic [7:0]  f_expo;
  logic [22:0] f_frac;
  logic        f_bad;
  logic [23:0] f_mant;
  logic [7:0]  f_shift;
  logic [33:0] f_prod, f_shifted;
  logic [Z_W-1:0] f_mm, raw_z;
  logic        raw_ok;

  // Float metres to whole millimetres: (mantissa * 1000) >> (150 - exponent).
  always_comb begin
    f_sign  = depth_word[31];
    f_expo  = depth_word[30:23];
    f_frac  = depth_word[22:0];
    f_bad   = (f_expo == 8'hFF) || (f_sign && (depth_word[30:0] != 31'd0));
    f_mant  = (f_expo == 8'd0) ? {1'b0, f_frac} : {1'b1, f_frac};
    f_shift = (f_expo == 8'd0) ? 8'd149 : 8'd150 - f_expo;
    f_prod  = 34'(f_mant) * 34'd1000;
    f_shifted = (f_shift >= 8'd34) ? 34'd0 : (f_prod >> f_shift);
    if (f_expo >= 8'd150) begin
      f_mm = 16'hFFFF;
    end else if (f_shifted > 34'd65535) begin
      f_mm = 16'hFFFF;
    end else begin
      f_mm = f_shifted[15:0];
    end
  end

  always_comb begin
    if (cfg.depth_format == FMT_FLOAT) begin
      raw_z  = f_mm;
      raw_ok = !f_bad;
    end else begin
      raw_z  = depth_word[15:0];
      raw_ok = 1'b1;
    end
    ok = raw_ok && (raw_z >= cfg.min_depth_mm) && (raw_z <= cfg.max_depth_mm);
    z  = raw_z;
  end

  always_comb begin
    u = frame_start ? '0 : col_r;
    v = frame_start ? '0 : row_r;
    if (cfg.image_width == 13'd0) begin
      limit = CNT_CMP_W'(1);
    end else if (CNT_CMP_W'(cfg.image_width) > CNT_CMP_W'(MAX_WIDTH)) begin
      limit = CNT_CMP_W'(MAX_WIDTH);
    end else begin
      limit = CNT_CMP_W'(cfg.image_width);
    end
    col_inc = CNT_CMP_W'(u) + 1'b1;
    row_inc = CNT_CMP_W'(v) + 1'b1;
    if (col_inc >= limit) begin
      col_nxt = '0;
      row_nxt = (row_inc >= CNT_CMP_W'(MAX_HEIGHT)) ? '0 : row_inc[RW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== rtl/dpp_back.sv =====
// ----------------------------------------------------------------------------
// dpp_back
// Projection engine: numerator multiply, bit-serial divide by the focal
// lengths, saturation and the result register.
// ----------------------------------------------------------------------------
module dpp_back
  import dpp_pkg::*;
#(
  parameter int CW = 12,
  parameter int RW = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   q_empty,
  input  logic                   q_ok,
  input  logic [Z_W-1:0]         q_z,
  input  logic [CW-1:0]          q_u,
  input  logic [RW-1:0]          q_v,
  output logic                   q_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic signed [XY_W-1:0] out_point_x,
  output logic signed [XY_W-1:0] out_point_y,
  output logic [Z_W-1:0]         out_point_z,
  output logic                   out_point_valid
);

  localparam int PW  = (CW > RW) ? CW : RW;
  localparam int DW  = ((PW + 4 > 16) ? PW + 4 : 16) + 1;
  localparam int NW  = DW + 16;
  localparam int NCW = $clog2(NW);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_HOLD} state_t;

  state_t          state_r;
  logic            ok_r;
  logic [Z_W-1:0]  z_r;
  logic [PW-1:0]   u_r, v_r;
  logic            neg_x_r, neg_y_r;
  logic [NW-1:0]   nq_x_r, nq_y_r;
  logic [16:0]     rem_x_r, rem_y_r;
  logic [NCW-1:0]  cnt_r;
  logic            out_valid_r;
  logic signed [XY_W-1:0] out_x_r, out_y_r;
  logic [Z_W-1:0]  out_z_r;
  logic            out_ok_r;

  logic [15:0]     den_x, den_y;
  logic signed [DW-1:0]  diff_x, diff_y;
  logic signed [DW+16:0] prod_x, prod_y;
  logic [DW+16:0]  mag_x, mag_y;
  logic [NW+16:0]  step_x, step_y;
  logic            out_free;

  // One restoring division step over {remainder, numerator/quotient}.
  function automatic logic [NW+16:0] div_step(input logic [16:0] rem,
                                              input logic [NW-1:0] nq,
                                              input logic [15:0] den);
    logic [16:0] rs;
    logic        bit_q;
    rs    = {rem[15:0], nq[NW-1]};
    bit_q = (rs >= {1'b0, den});
    if (bit_q) begin
      rs = rs - {1'b0, den};
    end
    return {rs, nq[NW-2:0], bit_q};
  endfunction

  function automatic logic [XY_W-1:0] sat32(input logic neg, input logic [NW-1:0] q);
    logic [NW-1:0] lim_neg, lim_pos, nq;
    lim_neg = NW'(33'h080000000);
    lim_pos = NW'(33'h07FFFFFFF);
    nq      = -q;
    if (neg) begin
      return (q > lim_neg) ? 32'h80000000 : nq[XY_W-1:0];
    end else begin
      return (q > lim_pos) ? 32'h7FFFFFFF : q[XY_W-1:0];
    end
  endfunction

  assign den_x    = (cfg.focal_x == 16'd0) ? 16'd1 : cfg.focal_x;
  assign den_y    = (cfg.focal_y == 16'd0) ? 16'd1 : cfg.focal_y;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || out_pop;

  always_comb begin
    diff_x = $signed({{(DW-PW-4){1'b0}}, u_r, 4'b0}) - $signed({{(DW-16){1'b0}}, cfg.center_x});
    diff_y = $signed({{(DW-PW-4){1'b0}}, v_r, 4'b0}) - $signed({{(DW-16){1'b0}}, cfg.center_y});
    prod_x = diff_x * $signed({1'b0, z_r});
    prod_y = diff_y * $signed({1'b0, z_r});
    mag_x  = prod_x[DW+16] ? -prod_x : prod_x;
    mag_y  = prod_y[DW+16] ? -prod_y : prod_y;
    step_x = div_step(rem_x_r, nq_x_r, den_x);
    step_y = div_step(rem_y_r, nq_y_r, den_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            ok_r    <= q_ok;
            z_r     <= q_ok ? q_z : '0;
            u_r     <= PW'(q_u);
            v_r     <= PW'(q_v);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          neg_x_r <= prod_x[DW+16];
          neg_y_r <= prod_y[DW+16];
          nq_x_r  <= mag_x[NW-1:0];
          nq_y_r  <= mag_y[NW-1:0];
          rem_x_r <= '0;
          rem_y_r <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_x_r <= step_x[NW+16:NW];
          nq_x_r  <= step_x[NW-1:0];
          rem_y_r <= step_y[NW+16:NW];
          nq_y_r  <= step_y[NW-1:0];
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == NCW'(NW - 1)) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_x_r     <= ok_r ? sat32(neg_x_r, nq_x_r) : '0;
            out_y_r     <= ok_r ? sat32(neg_y_r, nq_y_r) : '0;
            out_z_r     <= ok_r ? z_r : '0;
            out_ok_r    <= ok_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_z     = out_z_r;
  assign out_point_valid = out_ok_r;

endmodule

// ===== rtl/depth_pixel_to_point.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Pinhole back-projection of a raster stream of depth pixels.
// ----------------------------------------------------------------------------
// Input: drive in_depth_word and in_frame_start and raise in_push; the pixel
// is taken on an edge where in_full is low. in_frame_start marks column 0,
// row 0 of a new frame. Results come out in order: while out_empty is low
// the oldest point is on the out_ ports and out_pop takes it.
// Configuration writes (cfg_valid, cfg_index, cfg_data) are always ready
// and must be made while no pixel is in flight.
// Each pixel is read from the queue, multiplied, run through a bit-serial
// divider by the focal lengths that yields one bit per cycle over NW bits,
// where NW = 33 at the default sizes, and written to the result register.
// The serial divider sets the throughput: a new pixel waits for the last.
// The front end takes pixels into a two-entry queue, so a few pixels are
// accepted ahead of the divider. When the receiver stalls, the finished
// point waits in the result register, the divider holds its next result,
// and in_full rises once the queue fills. Reset empties everything, clears
// the column and row counters and restores the register defaults.
// ----------------------------------------------------------------------------
module depth_pixel_to_point
  import dpp_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [31:0]            in_depth_word,
  input  logic                   in_frame_start,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic signed [XY_W-1:0] out_point_x,
  output logic signed [XY_W-1:0] out_point_y,
  output logic [Z_W-1:0]         out_point_z,
  output logic                   out_point_valid,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int EW = 1 + Z_W + CW + RW;

  cfg_t           cfg_r;
  logic           accept;
  logic           f_ok;
  logic [Z_W-1:0] f_z;
  logic [CW-1:0]  f_u;
  logic [RW-1:0]  f_v;
  logic [EW-1:0]  q_rdata;
  logic           q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_format <= FMT_MM;
      cfg_r.min_depth_mm <= 16'd100;
      cfg_r.max_depth_mm <= 16'd10000;
      cfg_r.focal_x      <= 16'd8192;
      cfg_r.focal_y      <= 16'd8192;
      cfg_r.center_x     <= 16'd5120;
      cfg_r.center_y     <= 16'd3840;
      cfg_r.image_width  <= 13'd640;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEPTH_FORMAT: cfg_r.depth_format <= cfg_data[0];
        REG_MIN_DEPTH:    cfg_r.min_depth_mm <= cfg_data;
        REG_MAX_DEPTH:    cfg_r.max_depth_mm <= cfg_data;
        REG_FOCAL_X:      cfg_r.focal_x      <= cfg_data;
        REG_FOCAL_Y:      cfg_r.focal_y      <= cfg_data;
        REG_CENTER_X:     cfg_r.center_x     <= cfg_data;
        REG_CENTER_Y:     cfg_r.center_y     <= cfg_data;
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  dpp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .depth_word  (in_depth_word),
    .frame_start (in_frame_start),
    .ok          (f_ok),
    .z           (f_z),
    .u           (f_u),
    .v           (f_v)
  );

  dpp_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata ({f_ok, f_z, f_u, f_v}),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  dpp_back #(
    .CW (CW),
    .RW (RW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_ok            (q_rdata[EW-1]),
    .q_z             (q_rdata[EW-2 -: Z_W]),
    .q_u             (q_rdata[CW+RW-1:RW]),
    .q_v             (q_rdata[RW-1:0]),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_z     (out_point_z),
    .out_point_valid (out_point_valid)
  );

endmodule

// ===== rtl/dpp_checker.sv =====
// ----------------------------------------------------------------------------
// dpp_checker
// Port-level checks for depth_pixel_to_point, bound to the top level.
// ----------------------------------------------------------------------------
module dpp_checker
  import dpp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_full,
  input logic                   out_empty,
  input logic                   out_pop,
  input logic signed [XY_W-1:0] out_point_x,
  input logic signed [XY_W-1:0] out_point_y,
  input logic [Z_W-1:0]         out_point_z,
  input logic                   out_point_valid
);

  // Reset leaves nothing to deliver.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending right after reset");

  // Reset leaves room for input.
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("queue full right after reset");

  // An invalid point carries all-zero coordinates.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_point_valid) |->
      (out_point_x == 0 && out_point_y == 0 && out_point_z == 0))
    else $error("invalid point with nonzero coordinates");

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_point_x) && $stable(out_point_y) &&
       $stable(out_point_z) && $stable(out_point_valid)))
    else $error("stalled result changed");

endmodule

bind depth_pixel_to_point dpp_checker u_dpp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_point_x     (out_point_x),
  .out_point_y     (out_point_y),
  .out_point_z     (out_point_z),
  .out_point_valid (out_point_valid)
);
